[src/pfrse_pkg.sv]
// Shared types, constants and GF(929) arithmetic helpers for the Reed-Solomon encoder.
`default_nettype none

package pfrse_pkg;

  // Largest number of check codewords the block supports.
  localparam int MAX_CHECK = 64;
  // Index into the coefficient stores and the width of a check count.
  localparam int IDX_W = $clog2(MAX_CHECK);
  localparam int CNT_W = $clog2(MAX_CHECK + 1);

  localparam int WORD_W  = 10;
  localparam int LEVEL_W = 4;
  localparam int PROD_W  = 2 * WORD_W;

  localparam logic [WORD_W-1:0] PRIME = 10'd929;

  // Barrett reduction: floor(p / 929) == (p * BARRETT_MULT) >> BARRETT_SHIFT
  // exactly for every product of two residues.
  localparam int BARRETT_SHIFT = 30;
  localparam int BARRETT_W     = 21;
  localparam logic [BARRETT_W-1:0] BARRETT_MULT = 21'd1155804;
  localparam int BQ_W = PROD_W + BARRETT_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             item_load;
    logic             root_init;
    logic             root_step;
    logic             t_calc;
    logic             issue;
    logic             issue_gen;
    logic             issue_first;
    logic [IDX_W-1:0] issue_idx;
    logic             rd_rem;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
    logic             out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_status_t;

  // Sum of two residues, reduced.
  function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[WORD_W-1:0];
  endfunction

  // Additive inverse of a residue.
  function automatic logic [WORD_W-1:0] mod_neg(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] r;
    r = (a == '0) ? '0 : PRIME - a;
    return r;
  endfunction

  // Three times a residue, reduced.
  function automatic logic [WORD_W-1:0] mod_triple(input logic [WORD_W-1:0] a);
    logic [WORD_W+1:0] t;
    t = 12'(a) * 12'd3;
    if (t >= 12'(2 * 929)) begin
      t = t - 12'(2 * 929);
    end else if (t >= 12'(PRIME)) begin
      t = t - 12'(PRIME);
    end
    return t[WORD_W-1:0];
  endfunction

  // Reduce a raw 10-bit codeword into the field.
  function automatic logic [WORD_W-1:0] mod_reduce(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] r;
    r = (a >= PRIME) ? a - PRIME : a;
    return r;
  endfunction

  // Check count for a level: two to the level plus one, none when negative,
  // clamped to the store depth.
  function automatic logic [CNT_W-1:0] level_to_count(input logic [LEVEL_W-1:0] lvl);
    logic [9:0]       kw;
    logic [CNT_W-1:0] k;
    kw = 10'd1 << ({1'b0, lvl[2:0]} + 4'd1);
    if (lvl[3]) begin
      k = '0;
    end else if (kw > 10'(MAX_CHECK)) begin
      k = CNT_W'(MAX_CHECK);
    end else begin
      k = kw[CNT_W-1:0];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[src/pfrse_modmul.sv]
// Three-stage pipelined multiplier modulo 929 with Barrett reduction.
`default_nettype none

module pfrse_modmul import pfrse_pkg::*; (
  input  logic              clk,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] prod
);

  logic [PROD_W-1:0] p1_r;
  logic [PROD_W-1:0] p2_r;
  logic [WORD_W-1:0] q2_r;
  logic [WORD_W-1:0] r3_r;
  logic [BQ_W-1:0]   bq;
  logic [PROD_W-1:0] qm;
  logic [PROD_W-1:0] diff;

  // Stage one: plain product of two residues.
  always_ff @(posedge clk) begin
    p1_r <= PROD_W'(a) * PROD_W'(b);
  end

  // Stage two: quotient estimate, exact for this product range.
  assign bq = BQ_W'(p1_r) * BQ_W'(BARRETT_MULT);

  always_ff @(posedge clk) begin
    q2_r <= bq[BARRETT_SHIFT+WORD_W-1:BARRETT_SHIFT];
    p2_r <= p1_r;
  end

  // Stage three: subtract the multiple of the prime.
  assign qm   = PROD_W'(q2_r) * PROD_W'(PRIME);
  assign diff = p2_r - qm;

  always_ff @(posedge clk) begin
    r3_r <= diff[WORD_W-1:0];
  end

  assign prod = r3_r;

endmodule

`default_nettype wire

[src/pfrse_datapath.sv]
// Coefficient stores, multiply-accumulate pipeline and output register of the encoder.
`default_nettype none

module pfrse_datapath import pfrse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_check_word,
  output logic              out_last_check
);

  logic [WORD_W-1:0] gen_mem [MAX_CHECK];
  logic [WORD_W-1:0] rem_mem [MAX_CHECK];

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] coef_r;
  logic [WORD_W-1:0] gen_rd_r;
  logic [WORD_W-1:0] rem_rd_r;
  logic [WORD_W-1:0] carry_r;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic              gen1_r, gen2_r, gen3_r, gen4_r;
  logic              first1_r;
  logic [IDX_W-1:0]  j1_r, j2_r, j3_r, j4_r;
  logic [WORD_W-1:0] x2_r, x3_r, x4_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  gen_raddr;
  logic [IDX_W-1:0]  rem_raddr;
  logic              rem_rd_en;
  logic [WORD_W-1:0] x1;
  logic [WORD_W-1:0] y1;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] wr_data;

  // Read addresses: the generator build reads one below the element and
  // feeds the element's own coefficient from the carry register.
  assign gen_raddr = cmd.issue_gen ? cmd.issue_idx - IDX_W'(1) : cmd.issue_idx;
  assign rem_raddr = cmd.rd_rem ? cmd.rd_addr : cmd.issue_idx - IDX_W'(1);
  assign rem_rd_en = cmd.rd_rem | (cmd.issue & ~cmd.issue_gen);

  // Generator store: written from the last pipeline stage, read on issue.
  always_ff @(posedge clk) begin
    if (v4_r && gen4_r) begin
      gen_mem[j4_r] <= wr_data;
    end
    if (cmd.issue) begin
      gen_rd_r <= gen_mem[gen_raddr];
    end
  end

  // Remainder store: cleared alongside the generator build, updated by the
  // division step.
  always_ff @(posedge clk) begin
    if (v4_r) begin
      rem_mem[j4_r] <= gen4_r ? '0 : wr_data;
    end
    if (rem_rd_en) begin
      rem_rd_r <= rem_mem[rem_raddr];
    end
  end

  // Item register and the shared coefficient (root or negated feedback).
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      data_r <= mod_reduce(in_data_word);
    end
    if (cmd.root_init) begin
      coef_r <= PRIME - WORD_W'(1);
    end else if (cmd.root_step) begin
      coef_r <= mod_triple(coef_r);
    end else if (cmd.t_calc) begin
      coef_r <= mod_neg(mod_add(data_r, rem_rd_r));
    end
  end

  // Operand selection once the store data is back.
  always_comb begin
    if (j1_r == '0) begin
      x1 = '0;
    end else begin
      x1 = gen1_r ? gen_rd_r : rem_rd_r;
    end
    if (gen1_r) begin
      y1 = first1_r ? WORD_W'(1) : carry_r;
    end else begin
      y1 = gen_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      carry_r <= x1;
    end
  end

  pfrse_modmul u_modmul (
    .clk  (clk),
    .a    (coef_r),
    .b    (y1),
    .prod (prod)
  );

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Sideband that travels alongside the multiplier.
  always_ff @(posedge clk) begin
    j1_r     <= cmd.issue_idx;
    gen1_r   <= cmd.issue_gen;
    first1_r <= cmd.issue_first;
    j2_r     <= j1_r;
    gen2_r   <= gen1_r;
    x2_r     <= x1;
    j3_r     <= j2_r;
    gen3_r   <= gen2_r;
    x3_r     <= x2_r;
    j4_r     <= j3_r;
    gen4_r   <= gen3_r;
    x4_r     <= x3_r;
  end

  assign wr_data = mod_add(prod, x4_r);

  // Output register: holds a check word until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= mod_neg(rem_rd_r);
      out_last_r <= cmd.out_last;
    end
  end

  assign status.busy     = v1_r | v2_r | v3_r | v4_r;
  assign status.out_free = ~out_valid_r | ~out_stall;

  assign out_valid      = out_valid_r;
  assign out_check_word = out_word_r;
  assign out_last_check = out_last_r;

endmodule

`default_nettype wire

[src/pfrse_ctrl.sv]
// Controller state machine: message start, generator build, division step and readout.
`default_nettype none

module pfrse_ctrl import pfrse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_is_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_ecc_level,
  input  dp_status_t         status,
  output dp_cmd_t            cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_GEN_START  = 4'd1;
  localparam logic [3:0] S_GEN_SWEEP  = 4'd2;
  localparam logic [3:0] S_GEN_DRAIN  = 4'd3;
  localparam logic [3:0] S_T_READ     = 4'd4;
  localparam logic [3:0] S_T_CALC     = 4'd5;
  localparam logic [3:0] S_LFSR_SWEEP = 4'd6;
  localparam logic [3:0] S_LFSR_DRAIN = 4'd7;
  localparam logic [3:0] S_OUT_RD     = 4'd8;
  localparam logic [3:0] S_OUT_LOAD   = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   oj_r, oj_nxt;
  logic               last_r, last_nxt;
  logic               in_msg_r, in_msg_nxt;

  logic               accept;
  logic [CNT_W-1:0]   k_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & (state_r == S_IDLE);
  assign k_new     = level_to_count(level_r);

  // Next state and command decode.
  always_comb begin
    state_nxt  = state_r;
    level_nxt  = level_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    oj_nxt     = oj_r;
    last_nxt   = last_r;
    in_msg_nxt = in_msg_r;
    cmd        = '0;

    if (cfg_valid) begin
      level_nxt = cfg_ecc_level;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.item_load = 1'b1;
          last_nxt      = in_is_last;
          if (!in_msg_r) begin
            // First item of a message: latch the check count.
            k_nxt      = k_new;
            in_msg_nxt = 1'b1;
            if (k_new == '0) begin
              if (in_is_last) begin
                in_msg_nxt = 1'b0;
              end
            end else begin
              cmd.root_init = 1'b1;
              i_nxt         = CNT_W'(1);
              j_nxt         = '0;
              state_nxt     = S_GEN_START;
            end
          end else if (k_r == '0) begin
            if (in_is_last) begin
              in_msg_nxt = 1'b0;
            end
          end else begin
            state_nxt = S_T_READ;
          end
        end
      end

      S_GEN_START: begin
        // Advance the root to -(3^i) for this round.
        cmd.root_step = 1'b1;
        state_nxt     = S_GEN_SWEEP;
      end

      S_GEN_SWEEP: begin
        cmd.issue       = 1'b1;
        cmd.issue_gen   = 1'b1;
        cmd.issue_idx   = j_r;
        cmd.issue_first = (CNT_W'(j_r) == i_r - CNT_W'(1));
        if (j_r == '0) begin
          state_nxt = S_GEN_DRAIN;
        end else begin
          j_nxt = j_r - IDX_W'(1);
        end
      end

      S_GEN_DRAIN: begin
        // Each round reads what the previous one wrote, so let it settle.
        if (!status.busy) begin
          if (i_r == k_r) begin
            state_nxt = S_T_READ;
          end else begin
            j_nxt     = i_r[IDX_W-1:0];
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_GEN_START;
          end
        end
      end

      S_T_READ: begin
        cmd.rd_rem  = 1'b1;
        cmd.rd_addr = IDX_W'(k_r - CNT_W'(1));
        state_nxt   = S_T_CALC;
      end

      S_T_CALC: begin
        cmd.t_calc = 1'b1;
        j_nxt      = IDX_W'(k_r - CNT_W'(1));
        state_nxt  = S_LFSR_SWEEP;
      end

      S_LFSR_SWEEP: begin
        cmd.issue     = 1'b1;
        cmd.issue_idx = j_r;
        if (j_r == '0) begin
          state_nxt = S_LFSR_DRAIN;
        end else begin
          j_nxt = j_r - IDX_W'(1);
        end
      end

      S_LFSR_DRAIN: begin
        if (!status.busy) begin
          if (last_r) begin
            oj_nxt    = k_r;
            state_nxt = S_OUT_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_OUT_RD: begin
        cmd.rd_rem  = 1'b1;
        cmd.rd_addr = IDX_W'(oj_r - CNT_W'(1));
        state_nxt   = S_OUT_LOAD;
      end

      S_OUT_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (oj_r == CNT_W'(1));
          if (oj_r == CNT_W'(1)) begin
            in_msg_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            oj_nxt    = oj_r - CNT_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      level_r  <= '0;
      k_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      oj_r     <= '0;
      last_r   <= 1'b0;
      in_msg_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      level_r  <= level_nxt;
      k_r      <= k_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      oj_r     <= oj_nxt;
      last_r   <= last_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

`default_nettype wire

[src/prime_field_reed_solomon_encoder.sv]
// Top level of the GF(929) Reed-Solomon check codeword encoder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_data_word[9:0], in_is_last
//   out_     output     out_valid / out_stall out_check_word[9:0], out_last_check
//   cfg_     input      cfg_valid / cfg_ready cfg_ecc_level[3:0] (signed)
//
// At the first item of a message with k check words the generator is built in
// k rounds in the shared three-stage multiplier. Each data item then passes
// through the same multiplier pipeline, and each check word is read through
// the remainder store's read port.
// Reset is synchronous; the coefficient stores need no clearing pass.
// A stalled output holds the check word; readout waits until it is taken.
`default_nettype none

module prime_field_reed_solomon_encoder import pfrse_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [WORD_W-1:0]         in_data_word,
  input  logic                      in_is_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [WORD_W-1:0]         out_check_word,
  output logic                      out_last_check,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [LEVEL_W-1:0] cfg_ecc_level
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pfrse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_is_last    (in_is_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_ecc_level (cfg_ecc_level),
    .status        (status),
    .cmd           (cmd)
  );

  pfrse_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_data_word   (in_data_word),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_check_word (out_check_word),
    .out_last_check (out_last_check)
  );

endmodule

`default_nettype wire

[tb/gf929_check_pkg.sv]
// Scoreboard for the GF(929) Reed-Solomon encoder: predicts check words and compares them.
package gf929_check_pkg;

  import pfrse_pkg::*;

  localparam int unsigned FIELD_PRIME = 929;

  // One expected check codeword and its end-of-run flag.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } check_item_t;

  class gf929_check_tracker;

    logic [LEVEL_W-1:0] level;
    int unsigned        rem_coef[MAX_CHECK];
    int unsigned        gen_coef[MAX_CHECK];
    bit                 msg_open;
    int unsigned        num_checks;
    check_item_t        pending_checks[$];
    int                 errors;

    function new();
      level      = '0;
      msg_open   = 1'b0;
      num_checks = 0;
      errors     = 0;
      foreach (rem_coef[i]) begin
        rem_coef[i] = 0;
        gen_coef[i] = 0;
      end
    endfunction

    function void set_level(logic [LEVEL_W-1:0] v);
      level = v;
    endfunction

    // Negative levels give no check words; large levels are clamped to the store depth.
    function int unsigned checks_for_level(logic [LEVEL_W-1:0] v);
      int unsigned k;
      if (v[LEVEL_W-1]) begin
        return 0;
      end
      k = 1 << (int'(v) + 1);
      if (k > MAX_CHECK) begin
        k = MAX_CHECK;
      end
      return k;
    endfunction

    // Monic generator: product of (x - 3^i) for i = 1..k, leading one implied.
    function void build_generator(int unsigned k);
      int unsigned poly[MAX_CHECK+1];
      int unsigned root;
      root = FIELD_PRIME - 1;
      foreach (poly[i]) begin
        poly[i] = 0;
      end
      poly[0] = 1;
      for (int i = 1; i <= k; i++) begin
        // The root holds the negated power of three.
        root = (3 * root) % FIELD_PRIME;
        for (int j = i; j > 0; j--) begin
          poly[j] = (poly[j-1] + root * poly[j]) % FIELD_PRIME;
        end
        poly[0] = (root * poly[0]) % FIELD_PRIME;
      end
      for (int i = 0; i < MAX_CHECK; i++) begin
        gen_coef[i] = (i < k) ? poly[i] : 0;
      end
    endfunction

    // Divides one accepted data codeword into the remainder; a last item
    // queues the negated remainder, highest degree first.
    function void absorb_codeword(logic [WORD_W-1:0] raw, logic is_last);
      int unsigned d;
      int unsigned fb;
      check_item_t item;
      if (!msg_open) begin
        num_checks = checks_for_level(level);
        build_generator(num_checks);
        foreach (rem_coef[i]) begin
          rem_coef[i] = 0;
        end
        msg_open = 1'b1;
      end
      d = {22'd0, raw} % FIELD_PRIME;
      if (num_checks > 0) begin
        fb = (d + rem_coef[num_checks-1]) % FIELD_PRIME;
        for (int j = num_checks - 1; j > 0; j--) begin
          rem_coef[j] = (rem_coef[j-1] + FIELD_PRIME - (fb * gen_coef[j]) % FIELD_PRIME)
                        % FIELD_PRIME;
        end
        rem_coef[0] = (FIELD_PRIME - (fb * gen_coef[0]) % FIELD_PRIME) % FIELD_PRIME;
      end
      if (is_last) begin
        for (int j = num_checks; j > 0; j--) begin
          item.word = WORD_W'((FIELD_PRIME - rem_coef[j-1]) % FIELD_PRIME);
          item.last = (j == 1);
          pending_checks.push_back(item);
        end
        msg_open = 1'b0;
      end
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void compare_check_word(logic [WORD_W-1:0] word, logic last);
      check_item_t want;
      if (pending_checks.size() == 0) begin
        $error("unexpected check_word %0d with last_check %0b", word, last);
        errors++;
        return;
      end
      want = pending_checks.pop_front();
      if (word !== want.word) begin
        $error("check_word mismatch: expected %0d, actual %0d", want.word, word);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_check mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_checks.size();
    endfunction

    function void flag_leftovers();
      if (pending_checks.size() != 0) begin
        $error("%0d expected check words never arrived", pending_checks.size());
        errors++;
      end
    endfunction

  endclass

endpackage

[tb/testbench.sv]
// Top-level testbench for the GF(929) Reed-Solomon check codeword encoder.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import pfrse_pkg::*;
  import gf929_check_pkg::*;

  // Longest generator build (64 rounds) plus one data item, with margin.
  localparam int SETTLE_CYCLES  = 2600;
  localparam int TAIL_CYCLES    = 200;
  localparam int TIMEOUT_NS     = 80_000_000;
  localparam int RANDOM_PHASES  = 10;
  localparam int ITEMS_PER_PHASE = 46;

  int phase_level[RANDOM_PHASES] = '{1, 0, -1, 2, 5, 3, 4, 6, -5, 2};

  logic                      clk;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic [WORD_W-1:0]         in_data_word   = '0;
  logic                      in_is_last     = 1'b0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic [WORD_W-1:0]         out_check_word;
  logic                      out_last_check;
  logic                      cfg_valid      = 1'b0;
  logic                      cfg_ready;
  logic signed [LEVEL_W-1:0] cfg_ecc_level  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  gf929_check_tracker tracker = new();

  prime_field_reed_solomon_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_check_word (out_check_word),
    .out_last_check (out_last_check),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_ecc_level  (cfg_ecc_level)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog against a hung block.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Observe every transaction at the edge and drive random receiver stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        tracker.set_level(cfg_ecc_level);
      end
      if (in_valid && !in_stall) begin
        tracker.absorb_codeword(in_data_word, in_is_last);
      end
      if (out_valid && !out_stall) begin
        tracker.compare_check_word(out_check_word, out_last_check);
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one data codeword, with random idle cycles first, until accepted.
  task automatic send_codeword(logic [WORD_W-1:0] word, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_word <= word;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits for the block to go quiet, then writes the error correction level.
  task automatic write_level(logic signed [LEVEL_W-1:0] lvl);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_ecc_level <= lvl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform codewords, with the field edges and the top of the range mixed in.
  function automatic logic [WORD_W-1:0] pick_codeword();
    logic [WORD_W-1:0] w;
    case ($urandom_range(15))
      0: w = 10'd0;
      1: w = 10'd928;
      2: w = 10'd929;
      3: w = 10'd1023;
      default: w = WORD_W'($urandom_range(1023));
    endcase
    return w;
  endfunction

  initial begin
    int left;
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 6;
    recv_stall_pct = 6;

    // Field extremes and values just above the prime at two check words.
    write_level(0);
    send_codeword(10'd0, 1'b0);
    send_codeword(10'd1023, 1'b1);
    send_codeword(10'd928, 1'b0);
    send_codeword(10'd929, 1'b1);
    // No check words: messages are absorbed silently.
    write_level(-1);
    send_codeword(10'd5, 1'b0);
    send_codeword(10'd1023, 1'b1);
    write_level(-8);
    send_codeword(10'd7, 1'b1);
    // Top level, clamped to the full store depth.
    write_level(7);
    send_codeword(10'd1023, 1'b0);
    send_codeword(10'd0, 1'b0);
    send_codeword(10'd928, 1'b1);
    // A level change inside a message only applies to the next message.
    write_level(1);
    send_codeword(10'd100, 1'b0);
    send_codeword(10'd200, 1'b0);
    write_level(3);
    send_codeword(10'd300, 1'b1);
    send_codeword(10'd400, 1'b1);
    write_level(5);
    send_codeword(10'd929, 1'b1);

    // Random messages of random length, one level and idling pattern per phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      write_level(LEVEL_W'(phase_level[p]));
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        len = $urandom_range(12, 1);
        if (len > left) begin
          len = left;
        end
        for (int i = 0; i < len; i++) begin
          send_codeword(pick_codeword(), i == len - 1);
        end
        left -= len;
      end
    end

    // Drain the outstanding check words and let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.flag_leftovers();
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/pfrse_pkg.sv
src/pfrse_modmul.sv
src/pfrse_datapath.sv
src/pfrse_ctrl.sv
src/prime_field_reed_solomon_encoder.sv
tb/gf929_check_pkg.sv
tb/testbench.sv
